// File: rtl/core/fpp_pkg.sv
// Shared widths, reset values and result codes of the fixed-step pulse pacer.
package fpp_pkg;

  localparam int unsigned TimeWidth   = 32;
  localparam int unsigned TickWidth   = 16;
  localparam int unsigned StreakWidth = 8;

  localparam logic [TickWidth-1:0]   TicksResetVal = 16'd100;
  localparam logic [StreakWidth-1:0] StreakLimit   = 8'd5;
  localparam logic [StreakWidth-1:0] StreakMax     = 8'd255;

  localparam int unsigned InDataWidth  = 32;
  localparam int unsigned OutDataWidth = 56;

  typedef enum logic [1:0] {
    OutcomeOnTime  = 2'd0,
    OutcomeCatchUp = 2'd1,
    OutcomeOverrun = 2'd2
  } outcome_e;

  localparam logic CmdCheck = 1'b0;
  localparam logic CmdQuery = 1'b1;

endpackage

// File: rtl/core/fixed_step_pulse_pacer_top.sv
// Fixed-step pulse pacer: input register, single-pass pacing logic, result register.
//
// Use:
//   Slave stream carries one item per transfer: tdata holds the current
//   free-running time, tuser the command (0 check and advance, 1 query).
//   Master stream returns one result per item: remaining wait ticks, pulse
//   number, outcome code and the stored overrun flag.
//   The period length is written through cfg_we_i / cfg_wdata_i while the
//   block is idle; it takes effect on the next item.
// Flow and throughput:
//   An item taken moves from the input register into the result register,
//   where its result is offered; a held result can delay the move. One
//   item per cycle is sustained while results are taken; the pacing state
//   is updated as each item passes from the input register to the result
//   register.
// Reset:
//   Both registers empty, mark, pulse count, late streak and overrun flag
//   zero, period 100 ticks.
// Stall:
//   A held result keeps the result register; the input register still
//   takes one item, after which tready falls until the result is taken.
module fixed_step_pulse_pacer_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [fpp_pkg::TickWidth-1:0]     cfg_wdata_i,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // [31:0] now_time
  input  logic [fpp_pkg::InDataWidth-1:0]   s_axis_tdata_i,
  // [0] cmd
  input  logic                              s_axis_tuser_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // [15:0] wait_ticks, [47:16] pulse_number, [49:48] outcome, [50] overrun,
  // [55:51] zero
  output logic [fpp_pkg::OutDataWidth-1:0]  m_axis_tdata_o
);

  logic [fpp_pkg::TickWidth-1:0]   period_q;
  logic [fpp_pkg::TimeWidth-1:0]   mark_q, mark_d;
  logic [fpp_pkg::TimeWidth-1:0]   pulse_q, pulse_d;
  logic [fpp_pkg::StreakWidth-1:0] streak_q, streak_d, streak_inc;
  logic                            ovr_q, ovr_d;

  logic                            in_valid_q;
  logic                            in_cmd_q;
  logic [fpp_pkg::TimeWidth-1:0]   in_now_q;

  logic                            out_valid_q;
  logic [fpp_pkg::TickWidth-1:0]   out_wait_q, wait_d;
  logic [fpp_pkg::TimeWidth-1:0]   out_pulse_q;
  fpp_pkg::outcome_e               out_outcome_q, outcome_d;
  logic                            out_ovr_q;

  logic                            advance;
  logic                            s_fire;
  logic [fpp_pkg::TimeWidth-1:0]   elapsed;
  logic [fpp_pkg::TimeWidth-1:0]   period_ext;
  logic [fpp_pkg::TimeWidth:0]     period_x2;
  logic                            on_time;
  logic                            in_period;
  logic                            overrun_hit;

  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;

  assign period_ext = {{(fpp_pkg::TimeWidth-fpp_pkg::TickWidth){1'b0}}, period_q};
  assign period_x2  = {1'b0, period_ext} << 1;
  assign elapsed    = in_now_q - mark_q;
  assign on_time    = elapsed <= period_ext;
  assign in_period  = elapsed < period_ext;
  assign streak_inc = (streak_q == fpp_pkg::StreakMax) ? streak_q
                                                       : streak_q + 8'd1;
  assign overrun_hit = (streak_inc > fpp_pkg::StreakLimit) ||
                       ({1'b0, elapsed} > period_x2);

  always_comb begin
    mark_d    = mark_q;
    pulse_d   = pulse_q;
    streak_d  = streak_q;
    ovr_d     = ovr_q;
    wait_d    = '0;
    outcome_d = fpp_pkg::OutcomeOnTime;
    if (in_cmd_q == fpp_pkg::CmdQuery) begin
      if (in_period) begin
        wait_d = period_q - elapsed[fpp_pkg::TickWidth-1:0];
      end
    end else begin
      pulse_d = pulse_q + 32'd1;
      priority if (on_time) begin
        wait_d   = period_q - elapsed[fpp_pkg::TickWidth-1:0];
        mark_d   = mark_q + period_ext;
        streak_d = '0;
        ovr_d    = 1'b0;
      end else if (overrun_hit) begin
        streak_d  = streak_inc;
        mark_d    = in_now_q;
        ovr_d     = 1'b1;
        outcome_d = fpp_pkg::OutcomeOverrun;
      end else begin
        streak_d  = streak_inc;
        mark_d    = mark_q + period_ext;
        ovr_d     = 1'b0;
        outcome_d = fpp_pkg::OutcomeCatchUp;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= fpp_pkg::TicksResetVal;
    end else if (cfg_we_i) begin
      period_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      mark_q      <= '0;
      pulse_q     <= '0;
      streak_q    <= '0;
      ovr_q       <= 1'b0;
    end else begin
      if (s_fire) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        mark_q      <= mark_d;
        pulse_q     <= pulse_d;
        streak_q    <= streak_d;
        ovr_q       <= ovr_d;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      in_cmd_q <= s_axis_tuser_i;
      in_now_q <= s_axis_tdata_i;
    end
    if (advance) begin
      out_wait_q    <= wait_d;
      out_pulse_q   <= pulse_d;
      out_outcome_q <= outcome_d;
      out_ovr_q     <= ovr_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {5'd0, out_ovr_q, out_outcome_q, out_pulse_q, out_wait_q};

  a_overrun_sets_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_outcome_q == fpp_pkg::OutcomeOverrun) |-> out_ovr_q)
    else $error("overrun outcome without stored overrun flag");

  a_wait_only_on_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_wait_q != '0) |-> (out_outcome_q == fpp_pkg::OutcomeOnTime))
    else $error("nonzero wait on a late outcome");

  a_check_bumps_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && in_cmd_q == fpp_pkg::CmdCheck) |=> (pulse_q == $past(pulse_q) + 32'd1))
    else $error("check did not advance the pulse count");

  a_query_keeps_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && in_cmd_q == fpp_pkg::CmdQuery) |=>
      ($stable(mark_q) && $stable(pulse_q) && $stable(streak_q)))
    else $error("query changed pacing state");

endmodule

// File: verif/fpp_pacing_checker.sv
// Pacing checker: predicts each pulse result from accepted transfers and compares the outputs.
module fpp_pacing_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [fpp_pkg::TickWidth-1:0]     cfg_wdata_i,
  input  logic                              s_tvalid_i,
  input  logic                              s_tready_i,
  input  logic [fpp_pkg::InDataWidth-1:0]   s_tdata_i,
  input  logic                              s_tuser_i,
  input  logic                              m_tvalid_i,
  input  logic                              m_tready_i,
  input  logic [fpp_pkg::OutDataWidth-1:0]  m_tdata_i,
  output int unsigned                       fail_count_o,
  output int unsigned                       pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic                          overrun;
    fpp_pkg::outcome_e             outcome;
    logic [fpp_pkg::TimeWidth-1:0] pulse_number;
    logic [fpp_pkg::TickWidth-1:0] wait_ticks;
  } pace_result_t;

  logic [fpp_pkg::TickWidth-1:0]   period;
  logic [fpp_pkg::TimeWidth-1:0]   mark;
  logic [fpp_pkg::TimeWidth-1:0]   pulses;
  logic [fpp_pkg::StreakWidth-1:0] streak;
  logic                            overrun_flag;
  pace_result_t                    due_results_q[$];
  int unsigned                     fails;

  function automatic pace_result_t pace_item(input logic cmd,
                                             input logic [fpp_pkg::TimeWidth-1:0] now);
    pace_result_t                  res;
    logic [fpp_pkg::TimeWidth-1:0] span;
    logic [fpp_pkg::TimeWidth-1:0] elapsed;
    res     = '0;
    span    = fpp_pkg::TimeWidth'(period);
    elapsed = now - mark;
    res.outcome = fpp_pkg::OutcomeOnTime;
    if (cmd == fpp_pkg::CmdQuery) begin
      if (elapsed < span) res.wait_ticks = fpp_pkg::TickWidth'(span - elapsed);
    end else begin
      if (elapsed <= span) begin
        res.wait_ticks = fpp_pkg::TickWidth'(span - elapsed);
        mark         = mark + span;
        streak       = '0;
        overrun_flag = 1'b0;
      end else begin
        if (streak != fpp_pkg::StreakMax) streak = streak + 1'b1;
        if (streak > fpp_pkg::StreakLimit || {1'b0, elapsed} > {span, 1'b0}) begin
          mark         = now;
          overrun_flag = 1'b1;
          res.outcome  = fpp_pkg::OutcomeOverrun;
        end else begin
          mark         = mark + span;
          overrun_flag = 1'b0;
          res.outcome  = fpp_pkg::OutcomeCatchUp;
        end
      end
      pulses = pulses + 1'b1;
    end
    res.pulse_number = pulses;
    res.overrun      = overrun_flag;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    pace_result_t got;
    pace_result_t want;
    if (!rst_ni) begin
      period       = fpp_pkg::TicksResetVal;
      mark         = '0;
      pulses       = '0;
      streak       = '0;
      overrun_flag = 1'b0;
      due_results_q.delete();
      fails        = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_we_i) period = cfg_wdata_i;
      if (s_tvalid_i && s_tready_i) due_results_q.push_back(pace_item(s_tuser_i, s_tdata_i));
      if (m_tvalid_i && m_tready_i) begin
        got = pace_result_t'(m_tdata_i[50:0]);
        if (due_results_q.size() == 0) begin
          $error("result 0x%h arrived with none due", m_tdata_i);
          fails++;
        end else begin
          want = due_results_q.pop_front();
          if (got.wait_ticks !== want.wait_ticks) begin
            $error("wait_ticks: expected %0d, got %0d", want.wait_ticks, got.wait_ticks);
            fails++;
          end
          if (got.pulse_number !== want.pulse_number) begin
            $error("pulse_number: expected %0d, got %0d", want.pulse_number, got.pulse_number);
            fails++;
          end
          if (got.outcome !== want.outcome) begin
            $error("outcome: expected %0d, got %0d", want.outcome, m_tdata_i[49:48]);
            fails++;
          end
          if (got.overrun !== want.overrun) begin
            $error("overrun: expected %0d, got %0d", want.overrun, got.overrun);
            fails++;
          end
          if (m_tdata_i[55:51] !== '0) begin
            $error("padding: expected 0, got 0x%h", m_tdata_i[55:51]);
            fails++;
          end
        end
      end
      fail_count_o <= fails;
      pending_o    <= $unsigned(due_results_q.size());
    end
  end

endmodule

// File: verif/tb.sv
// Testbench top: drives pacing items and period writes under varied flow control, gives the verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic                              clk_i = 1'b0;
  logic                              rst_ni = 1'b0;
  logic                              cfg_we;
  logic [fpp_pkg::TickWidth-1:0]     cfg_wdata;
  logic                              s_tvalid;
  logic                              s_tready;
  logic [fpp_pkg::InDataWidth-1:0]   s_tdata;
  logic                              s_tuser;
  logic                              m_tvalid;
  logic                              m_tready;
  logic [fpp_pkg::OutDataWidth-1:0]  m_tdata;
  int unsigned                       fail_count;
  int unsigned                       pending;

  int unsigned                       src_gap_pct;
  int unsigned                       sink_stall_pct;
  logic [fpp_pkg::TickWidth-1:0]     cur_period;
  logic [fpp_pkg::TimeWidth-1:0]     t_now;

  fixed_step_pulse_pacer_top u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  fpp_pacing_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .s_tvalid_i   (s_tvalid),
    .s_tready_i   (s_tready),
    .s_tdata_i    (s_tdata),
    .s_tuser_i    (s_tuser),
    .m_tvalid_i   (m_tvalid),
    .m_tready_i   (m_tready),
    .m_tdata_i    (m_tdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    m_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  task automatic send_item(input logic cmd, input logic [fpp_pkg::TimeWidth-1:0] now);
    while ($urandom_range(99) < src_gap_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= now;
    s_tuser  <= cmd;
    do @(posedge clk_i); while (!s_tready);
  endtask

  // drop valid, wait for every due result, then let the bench idle
  task automatic settle();
    s_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_period(input logic [fpp_pkg::TickWidth-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    cur_period = value;
  endtask

  task automatic set_idling(input int unsigned gap_pct, input int unsigned stall_pct);
    src_gap_pct    = gap_pct;
    sink_stall_pct = stall_pct;
  endtask

  task automatic run_phase(input int unsigned n_items);
    logic [fpp_pkg::TimeWidth-1:0] per;
    logic [fpp_pkg::TimeWidth-1:0] adv;
    int unsigned                   pick;
    per = fpp_pkg::TimeWidth'(cur_period);
    repeat (n_items) begin
      pick = $urandom_range(99);
      if (pick < 12) begin
        send_item(fpp_pkg::CmdQuery, t_now + $urandom_range(per + (per >> 1)));
      end else if (pick < 18) begin
        send_item(1'($urandom_range(1)), $urandom());
      end else begin
        pick = $urandom_range(99);
        if (per == 0) begin
          adv = (pick < 50) ? '0 : $urandom_range(3);
        end else if (pick < 65) begin
          adv = per - (per >> 3) + $urandom_range(per >> 2);
        end else if (pick < 85) begin
          adv = per + $urandom_range(per, 1);
        end else if (pick < 95) begin
          adv = 2 * per + $urandom_range(per, 1);
        end else begin
          adv = $urandom();
        end
        t_now += adv;
        send_item(fpp_pkg::CmdCheck, t_now);
      end
    end
  endtask

  initial begin
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= 1'b0;
    m_tready  <= 1'b0;
    set_idling(0, 0);
    cur_period = fpp_pkg::TicksResetVal;
    t_now      = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_item(fpp_pkg::CmdQuery, 32'd0);
    send_item(fpp_pkg::CmdQuery, 32'd100);
    send_item(fpp_pkg::CmdQuery, 32'hFFFF_FF00);
    send_item(fpp_pkg::CmdCheck, 32'd0);
    send_item(fpp_pkg::CmdCheck, 32'd200);
    send_item(fpp_pkg::CmdCheck, 32'd301);
    send_item(fpp_pkg::CmdCheck, 32'd600);
    send_item(fpp_pkg::CmdQuery, 32'd650);
    send_item(fpp_pkg::CmdCheck, 32'hFFFF_FFFF);
    send_item(fpp_pkg::CmdCheck, 32'h0000_0063);
    // late by half a period each time until the streak trips an overrun
    t_now = 32'h0000_0063 + 32'd150;
    send_item(fpp_pkg::CmdCheck, t_now);
    repeat (5) begin
      t_now += 32'd100;
      send_item(fpp_pkg::CmdCheck, t_now);
    end
    t_now += 32'd100;
    send_item(fpp_pkg::CmdCheck, t_now);
    send_item(fpp_pkg::CmdQuery, t_now + 32'd30);
    settle();

    write_period(16'd1);
    run_phase(250);
    settle();

    write_period(16'hFFFF);
    set_idling(66, 0);
    run_phase(250);
    settle();

    write_period(16'd0);
    set_idling(0, 66);
    run_phase(200);
    settle();

    write_period(16'($urandom_range(65534, 2)));
    set_idling(30, 30);
    run_phase(250);
    settle();

    write_period(fpp_pkg::TicksResetVal);
    set_idling(0, 0);
    run_phase(200);
    // sustained lag: drive the late streak into saturation
    repeat (270) begin
      t_now += fpp_pkg::TimeWidth'(cur_period) + 1 + $urandom_range(cur_period >> 2);
      send_item(fpp_pkg::CmdCheck, t_now);
    end
    settle();

    write_period(16'($urandom_range(500, 1)));
    set_idling(0, 66);
    run_phase(230);
    settle();

    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
